[rtl/core/gaq_pkg.sv]
// gaq_pkg: shared constants, register codes and helpers for the gray adjust
// and quantize pipeline. Used by gaq_hash, gaq_gamma and gray_adjust_and_quantize.
// No dependencies.
`timescale 1ns / 1ps

package gaq_pkg;

  // pipeline depth, from input register to output register
  localparam int NumStages = 9;

  // field widths
  localparam int GrayBits   = 8;
  localparam int FieldBits  = 16;
  localparam int CoordBits  = 16;
  localparam int LevelBits  = 2;
  localparam int InDataBits = 40;
  localparam int OutDataBits = 16;
  localparam int CfgDataBits = 9;
  localparam int CfgIndexBits = 3;

  // coordinate mask applied before hashing
  localparam logic [FieldBits-1:0] CoordMask =
    FieldBits'((33'd1 << CoordBits) - 33'd1);

  // hash multipliers and shift
  localparam logic [31:0] HashMulX   = 32'd374761393;
  localparam logic [31:0] HashMulY   = 32'd668265263;
  localparam logic [31:0] HashMulMix = 32'd1274126177;
  localparam int          HashShift  = 13;

  // divide by 100 as multiply by reciprocal, exact for magnitudes below 43690
  localparam logic [15:0] Recip100   = 16'd41944;
  localparam int          RecipShift = 22;

  // register reset values
  localparam logic [7:0] ContrastReset = 8'd135;
  localparam logic [7:0] LevelOneReset = 8'd45;
  localparam logic [7:0] LevelTwoReset = 8'd70;
  localparam logic [7:0] LevelThreeReset = 8'd140;

  // configuration register indexes
  typedef enum logic [CfgIndexBits-1:0] {
    REG_CONTRAST    = 3'd0,
    REG_BRIGHTNESS  = 3'd1,
    REG_GAMMA_EN    = 3'd2,
    REG_DITHER_EN   = 3'd3,
    REG_LEVEL_ONE   = 3'd4,
    REG_LEVEL_TWO   = 3'd5,
    REG_LEVEL_THREE = 3'd6
  } cfg_reg_t;

  // one restoring division step
  typedef struct packed {
    logic [7:0] rem;
    logic       qbit;
  } div_step_t;

  function automatic div_step_t div_step(logic [7:0] rem, logic din, logic [7:0] dvs);
    logic [8:0] trial;
    div_step_t  res;
    trial = {rem, din};
    if (trial >= {1'b0, dvs}) begin
      res.rem  = 8'(trial - {1'b0, dvs});
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial[7:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

[rtl/core/gaq_hash.sv]
// gaq_hash: coordinate hash for the noise dither, three register stages
// followed by a delay line to line up with the gray path. Uses gaq_pkg.
`timescale 1ns / 1ps

module gaq_hash (
  input  logic                           clk,
  input  logic [8:1]                     en,
  input  logic [gaq_pkg::FieldBits-1:0]  column,
  input  logic [gaq_pkg::FieldBits-1:0]  row,
  output logic [7:0]                     threshold
);

  logic [31:0] prod_x;
  logic [31:0] prod_y;
  logic [31:0] mixed;
  logic [7:0]  th_pipe [3:8];

  // stage 1: one product per coordinate
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_x <= {16'd0, column & gaq_pkg::CoordMask} * gaq_pkg::HashMulX;
      prod_y <= {16'd0, row & gaq_pkg::CoordMask} * gaq_pkg::HashMulY;
    end
  end

  // stage 2: sum and fold
  always_ff @(posedge clk) begin
    if (en[2]) begin
      mixed <= (prod_x + prod_y) ^ ((prod_x + prod_y) >> gaq_pkg::HashShift);
    end
  end

  // stage 3: final multiply, keep top byte
  logic [31:0] mix_prod;
  assign mix_prod = mixed * gaq_pkg::HashMulMix;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      th_pipe[3] <= mix_prod[31:24];
    end
    for (int i = 4; i <= 8; i++) begin
      if (en[i]) begin
        th_pipe[i] <= th_pipe[i-1];
      end
    end
  end

  assign threshold = th_pipe[8];

endmodule

[rtl/core/gaq_gamma.sv]
// gaq_gamma: square-root gamma curve, second newton step through a pipelined
// restoring divider, three quotient bits per stage. Uses gaq_pkg.
`timescale 1ns / 1ps

module gaq_gamma (
  input  logic                          clk,
  input  logic [8:4]                    en,
  input  logic                          gamma_enable,
  input  logic [gaq_pkg::GrayBits-1:0]  gray_in,
  output logic [gaq_pkg::GrayBits-1:0]  gray_out
);

  // stage 4: first newton step is exact, r1 = (g + 255) / 2
  logic [7:0]  s4_g, s4_r1;
  logic [15:0] s4_prod;
  // stages 5 to 7: divider state
  logic [7:0]  s5_g, s5_r1, s5_rem;
  logic [5:0]  s5_low;
  logic [8:0]  s5_q;
  logic [7:0]  s6_g, s6_r1, s6_rem;
  logic [2:0]  s6_low;
  logic [8:0]  s6_q;
  logic [7:0]  s7_g, s7_r1;
  logic [8:0]  s7_q;
  logic [7:0]  s8_gray;

  logic [7:0]  s5_rem_next, s6_rem_next;
  logic [8:0]  s5_q_next, s6_q_next, s7_q_next;
  logic [8:0]  r1_sum;
  logic [9:0]  r2_sum;
  logic [8:0]  r2;
  logic [7:0]  r2_cap;

  gaq_pkg::div_step_t st5, st6, st7;

  assign r1_sum = 9'(gray_in) + 9'd255;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_g    <= gray_in;
      s4_r1   <= r1_sum[8:1];
      s4_prod <= {gray_in, 8'd0} - {8'd0, gray_in};
    end
  end

  // quotient bits 8 to 6
  always_comb begin
    s5_rem_next = {1'b0, s4_prod[15:9]};
    s5_q_next   = '0;
    st5         = '0;
    for (int j = 0; j < 3; j++) begin
      st5         = gaq_pkg::div_step(s5_rem_next, s4_prod[8-j], s4_r1);
      s5_rem_next = st5.rem;
      s5_q_next   = {s5_q_next[7:0], st5.qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_g   <= s4_g;
      s5_r1  <= s4_r1;
      s5_rem <= s5_rem_next;
      s5_low <= s4_prod[5:0];
      s5_q   <= s5_q_next;
    end
  end

  // quotient bits 5 to 3
  always_comb begin
    s6_rem_next = s5_rem;
    s6_q_next   = s5_q;
    st6         = '0;
    for (int j = 0; j < 3; j++) begin
      st6         = gaq_pkg::div_step(s6_rem_next, s5_low[5-j], s5_r1);
      s6_rem_next = st6.rem;
      s6_q_next   = {s6_q_next[7:0], st6.qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_g   <= s5_g;
      s6_r1  <= s5_r1;
      s6_rem <= s6_rem_next;
      s6_low <= s5_low[2:0];
      s6_q   <= s6_q_next;
    end
  end

  // quotient bits 2 to 0, remainder no longer needed
  always_comb begin
    logic [7:0] rem;
    rem       = s6_rem;
    s7_q_next = s6_q;
    st7       = '0;
    for (int j = 0; j < 3; j++) begin
      st7       = gaq_pkg::div_step(rem, s6_low[2-j], s6_r1);
      rem       = st7.rem;
      s7_q_next = {s7_q_next[7:0], st7.qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_g  <= s6_g;
      s7_r1 <= s6_r1;
      s7_q  <= s7_q_next;
    end
  end

  // stage 8: second newton step, cap, zero kept as zero, bypass when gamma off
  assign r2_sum = 10'(s7_r1) + 10'(s7_q);
  assign r2     = r2_sum[9:1];
  assign r2_cap = (r2 > 9'd255) ? 8'd255 : r2[7:0];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      if (!gamma_enable || s7_g == 8'd0) begin
        s8_gray <= s7_g;
      end else begin
        s8_gray <= r2_cap;
      end
    end
  end

  assign gray_out = s8_gray;

endmodule

[rtl/core/gray_adjust_and_quantize.sv]
// gray_adjust_and_quantize: contrast, brightness, optional gamma and 2-bit
// quantizing of a gray pixel stream. Uses gaq_pkg, gaq_hash and gaq_gamma.
//
//   channel   | direction | tdata / fields (lsb first)                 | tuser
//   s_axis    | in        | pixel_gray[7:0] column[23:8] row[39:24]    | -
//   m_axis    | out       | level[1:0] adjusted_gray[9:2] zero[15:10]  | -
//   cfg       | in        | cfg_we, cfg_index (0..6), cfg_wdata[8:0]   | -
//
// one item per clock cycle sustained while m_axis is ready; the accepting edge
// loads stage 1 and the item moves through the 9 register stages (contrast
// multiply, divide by 100, clamps, first newton step, a 3-stage divider, second
// newton step, quantize), the last of which is the output register.
// every stage holds its own valid bit and loads when empty or when the next
// stage moves, so bubbles close up while m_axis is stalled.
// rst clears valid bits and loads register reset values; no clearing pass.
`timescale 1ns / 1ps

module gray_adjust_and_quantize (
  input  logic                              clk,
  input  logic                              rst,
  // pixel_gray[7:0], column[23:8], row[39:24]
  input  logic [gaq_pkg::InDataBits-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // level[1:0], adjusted_gray[9:2], zero fill[15:10]
  output logic [gaq_pkg::OutDataBits-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we,
  input  logic [gaq_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [gaq_pkg::CfgDataBits-1:0]   cfg_wdata
);

  // configuration registers
  logic [7:0]        contrast_percent;
  logic signed [8:0] brightness_offset;
  logic              gamma_enable;
  logic              dither_enable;
  logic [7:0]        level_one_threshold;
  logic [7:0]        level_two_threshold;
  logic [7:0]        level_three_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_percent      <= gaq_pkg::ContrastReset;
      brightness_offset     <= '0;
      gamma_enable          <= 1'b0;
      dither_enable         <= 1'b0;
      level_one_threshold   <= gaq_pkg::LevelOneReset;
      level_two_threshold   <= gaq_pkg::LevelTwoReset;
      level_three_threshold <= gaq_pkg::LevelThreeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gaq_pkg::REG_CONTRAST:    contrast_percent      <= cfg_wdata[7:0];
        gaq_pkg::REG_BRIGHTNESS:  brightness_offset     <= $signed(cfg_wdata);
        gaq_pkg::REG_GAMMA_EN:    gamma_enable          <= cfg_wdata[0];
        gaq_pkg::REG_DITHER_EN:   dither_enable         <= cfg_wdata[0];
        gaq_pkg::REG_LEVEL_ONE:   level_one_threshold   <= cfg_wdata[7:0];
        gaq_pkg::REG_LEVEL_TWO:   level_two_threshold   <= cfg_wdata[7:0];
        gaq_pkg::REG_LEVEL_THREE: level_three_threshold <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [7:0]  in_gray;
  logic [15:0] in_column;
  logic [15:0] in_row;

  assign in_gray   = s_axis_tdata[7:0];
  assign in_column = s_axis_tdata[23:8];
  assign in_row    = s_axis_tdata[39:24];

  // stage valid bits and load enables
  logic [gaq_pkg::NumStages:1] vld;
  logic [gaq_pkg::NumStages:1] en;

  always_comb begin
    en[gaq_pkg::NumStages] = !vld[gaq_pkg::NumStages] || m_axis_tready;
    for (int i = gaq_pkg::NumStages - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int i = 2; i <= gaq_pkg::NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_axis_tready = en[1];

  // stage 1: (gray - 128) * contrast
  logic signed [8:0]  centred;
  logic signed [17:0] con_mul;
  logic signed [16:0] s1_prod;

  assign centred = $signed({1'b0, in_gray}) - 9'sd128;
  assign con_mul = 18'(centred) * 18'($signed({1'b0, contrast_percent}));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod <= con_mul[16:0];
    end
  end

  // stage 2: magnitude divided by 100 through the reciprocal
  logic [16:0] mag;
  logic [30:0] recip_mul;
  logic        s2_neg;
  logic [8:0]  s2_q;

  assign mag       = s1_prod[16] ? 17'(-s1_prod) : s1_prod;
  assign recip_mul = 31'(mag[14:0]) * 31'(gaq_pkg::Recip100);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_neg <= s1_prod[16];
      s2_q   <= recip_mul[30:gaq_pkg::RecipShift];
    end
  end

  // stage 3: restore sign, add midpoint, clamp, add brightness, clamp
  logic signed [10:0] quot_s;
  logic signed [10:0] with_mid;
  logic [7:0]         con_clamped;
  logic signed [10:0] with_bright;
  logic [7:0]         s3_gray;

  assign quot_s   = s2_neg ? -$signed({2'b00, s2_q}) : $signed({2'b00, s2_q});
  assign with_mid = quot_s + 11'sd128;

  always_comb begin
    if (with_mid < 11'sd0) begin
      con_clamped = 8'd0;
    end else if (with_mid > 11'sd255) begin
      con_clamped = 8'd255;
    end else begin
      con_clamped = with_mid[7:0];
    end
  end

  assign with_bright = $signed({3'b000, con_clamped}) + 11'(brightness_offset);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (with_bright < 11'sd0) begin
        s3_gray <= 8'd0;
      end else if (with_bright > 11'sd255) begin
        s3_gray <= 8'd255;
      end else begin
        s3_gray <= with_bright[7:0];
      end
    end
  end

  // stages 4 to 8: gamma curve, beside the dither hash of stages 1 to 8
  logic [7:0] s8_gray;
  logic [7:0] s8_threshold;

  gaq_gamma u_gamma (
    .clk          (clk),
    .en           (en[8:4]),
    .gamma_enable (gamma_enable),
    .gray_in      (s3_gray),
    .gray_out     (s8_gray)
  );

  gaq_hash u_hash (
    .clk       (clk),
    .en        (en[8:1]),
    .column    (in_column),
    .row       (in_row),
    .threshold (s8_threshold)
  );

  // stage 9: quantize to 2 bits
  logic [9:0] s_triple;
  logic [1:0] dith_base;
  logic [7:0] dith_rem;
  logic [8:0] dith_sum;
  logic [1:0] dith_level;
  logic [1:0] thr_level;
  logic [1:0] s9_level;
  logic [7:0] s9_gray;

  assign s_triple = {1'b0, s8_gray, 1'b0} + 10'(s8_gray);

  always_comb begin
    priority if (s_triple < 10'd255) begin
      dith_base = 2'd0;
      dith_rem  = s_triple[7:0];
    end else if (s_triple < 10'd510) begin
      dith_base = 2'd1;
      dith_rem  = 8'(s_triple - 10'd255);
    end else begin
      dith_base = 2'd2;
      dith_rem  = 8'(s_triple - 10'd510);
    end
  end

  assign dith_sum   = 9'(dith_rem) + 9'(s8_threshold);
  assign dith_level = dith_base + 2'((dith_sum >= 9'd255) ? 1'b1 : 1'b0);

  // thresholds checked first-match, in order
  always_comb begin
    priority if (s8_gray < level_one_threshold) begin
      thr_level = 2'd0;
    end else if (s8_gray < level_two_threshold) begin
      thr_level = 2'd1;
    end else if (s8_gray < level_three_threshold) begin
      thr_level = 2'd2;
    end else begin
      thr_level = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_level <= dither_enable ? dith_level : thr_level;
      s9_gray  <= s8_gray;
    end
  end

  assign m_axis_tvalid = vld[gaq_pkg::NumStages];
  assign m_axis_tdata  = {6'd0, s9_gray, s9_level};

endmodule
